### sv/egcd_pkg.sv
// Package for the extended gcd / modular inverse block.
// Holds the default width and the controller-datapath command and status types.
// No dependencies.
package egcd_pkg;

    // Default coefficient width; operands are one bit narrower
    localparam int WIDTH_DEF = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // capture operands, seed coefficients
        logic start_div;  // clear remainder, quotient accumulators and bit counter
        logic div_step;   // one restoring-division bit
        logic update;     // rotate remainders and coefficients
        logic load_out;   // capture the result item
    } egcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic b_zero;     // current divisor is zero: algorithm finished
        logic cnt_last;   // last division bit this cycle
    } egcd_status_t;

endpackage

### sv/egcd_datapath.sv
// Datapath of the extended gcd block: remainders, coefficients, bit-serial divider.
// Depends on egcd_pkg for the command and status types.
module egcd_datapath
    import egcd_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  egcd_cmd_t               cmd,
    output egcd_status_t            status,
    input  logic [WIDTH-2:0]        value_a,
    input  logic [WIDTH-2:0]        value_b,
    output logic [WIDTH-2:0]        gcd_value,
    output logic signed [WIDTH-1:0] coef_x,
    output logic signed [WIDTH-1:0] coef_y,
    output logic [WIDTH-2:0]        inverse_value
);

    localparam int OW = WIDTH - 1;
    localparam int CW = WIDTH;
    localparam int CNTW = $clog2(OW);

    // Euclid state
    logic [OW-1:0]   a_reg, a_next;
    logic [OW-1:0]   b_reg, b_next;
    logic [OW-1:0]   mod_reg, mod_next;
    logic [CW-1:0]   xp_reg, xp_next, xc_reg, xc_next;
    logic [CW-1:0]   yp_reg, yp_next, yc_reg, yc_next;

    // Division state
    logic [OW-1:0]   n_reg, n_next;
    logic [OW-1:0]   r_reg, r_next;
    logic [CW-1:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    // Result item
    logic [OW-1:0]   gcd_reg, gcd_next;
    logic [CW-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [OW-1:0]   inv_reg, inv_next;

    logic [OW:0]     r_sh;
    logic            q_bit;
    logic [CW-1:0]   x_adj;

    // Shift the next dividend bit in and trial-subtract the divisor
    assign r_sh  = {r_reg, n_reg[OW-1]};
    assign q_bit = (r_sh >= {1'b0, b_reg});
    // Reduce a negative coefficient by adding the modulus once
    assign x_adj = xp_reg[CW-1] ? (xp_reg + {{(CW-OW){1'b0}}, mod_reg}) : xp_reg;

    assign status.b_zero   = (b_reg == '0);
    assign status.cnt_last = (cnt_reg == CNTW'(OW - 1));

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        mod_next = mod_reg;
        xp_next  = xp_reg;
        xc_next  = xc_reg;
        yp_next  = yp_reg;
        yc_next  = yc_reg;
        n_next   = n_reg;
        r_next   = r_reg;
        tx_next  = tx_reg;
        ty_next  = ty_reg;
        cnt_next = cnt_reg;
        gcd_next = gcd_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        inv_next = inv_reg;

        // Capture operands and seed the coefficient pairs
        if (cmd.load_in)
        begin
            a_next   = value_a;
            b_next   = value_b;
            mod_next = value_b;
            xp_next  = CW'(1);
            xc_next  = '0;
            yp_next  = '0;
            yc_next  = CW'(1);
        end

        // Prepare one quotient/remainder step
        if (cmd.start_div)
        begin
            n_next   = a_reg;
            r_next   = '0;
            tx_next  = '0;
            ty_next  = '0;
            cnt_next = '0;
        end

        // Advance the divider one bit, building q*xc and q*yc MSB first
        if (cmd.div_step)
        begin
            n_next   = {n_reg[OW-2:0], 1'b0};
            r_next   = q_bit ? OW'(r_sh - {1'b0, b_reg}) : r_sh[OW-1:0];
            tx_next  = {tx_reg[CW-2:0], 1'b0} + (q_bit ? xc_reg : '0);
            ty_next  = {ty_reg[CW-2:0], 1'b0} + (q_bit ? yc_reg : '0);
            cnt_next = cnt_reg + CNTW'(1);
        end

        // Rotate remainders and coefficients
        if (cmd.update)
        begin
            a_next  = b_reg;
            b_next  = r_reg;
            xp_next = xc_reg;
            xc_next = xp_reg - tx_reg;
            yp_next = yc_reg;
            yc_next = yp_reg - ty_reg;
        end

        // Capture the result item
        if (cmd.load_out)
        begin
            gcd_next = a_reg;
            cx_next  = xp_reg;
            cy_next  = yp_reg;
            inv_next = x_adj[OW-1:0];
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        mod_reg <= mod_next;
        xp_reg  <= xp_next;
        xc_reg  <= xc_next;
        yp_reg  <= yp_next;
        yc_reg  <= yc_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        gcd_reg <= gcd_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        inv_reg <= inv_next;
    end

    // Bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign gcd_value     = gcd_reg;
    assign coef_x        = cx_reg;
    assign coef_y        = cy_reg;
    assign inverse_value = inv_reg;

endmodule

### sv/egcd_controller.sv
// Controller of the extended gcd block: sequences division steps and output handshake.
// Depends on egcd_pkg for the command and status types.
module egcd_controller
    import egcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output egcd_cmd_t    cmd,
    input  egcd_status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // Drop the result item once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.b_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_FIN:
            begin
                // Hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### sv/extended_gcd_mod_inverse.sv
// Top level of the extended gcd / modular inverse block.
// Instantiates egcd_controller and egcd_datapath; uses egcd_pkg.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | value_a, value_b
//  out     | output    | out_valid / out_stall | gcd_value, coef_x, coef_y, inverse_value
//
// Each Euclid step runs a check, the bit-serial restoring divider and one
// coefficient update. An item takes at most 45 steps for 31-bit operands.
// One item is worked at a time; the next is accepted while a result still waits.
// Reset clears control state only. A stalled result holds its output register.
module extended_gcd_mod_inverse
    import egcd_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [WIDTH-2:0]        value_a,
    input  logic [WIDTH-2:0]        value_b,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [WIDTH-2:0]        gcd_value,
    output logic signed [WIDTH-1:0] coef_x,
    output logic signed [WIDTH-1:0] coef_y,
    output logic [WIDTH-2:0]        inverse_value
);

    egcd_cmd_t    cmd;
    egcd_status_t status;

    egcd_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    egcd_datapath #(.WIDTH(WIDTH)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .value_a       (value_a),
        .value_b       (value_b),
        .gcd_value     (gcd_value),
        .coef_x        (coef_x),
        .coef_y        (coef_y),
        .inverse_value (inverse_value)
    );

endmodule

### sv/egcd_checker.sv
// Port-level checker for extended_gcd_mod_inverse, attached by bind.
// Uses egcd_pkg for the default width.
module egcd_checker
    import egcd_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [WIDTH-2:0]        value_a,
    input logic [WIDTH-2:0]        value_b,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [WIDTH-2:0]        gcd_value,
    input logic signed [WIDTH-1:0] coef_x,
    input logic signed [WIDTH-1:0] coef_y,
    input logic [WIDTH-2:0]        inverse_value
);

    // A stalled result item stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // An accepted item stalls the input, and its result is not raised straight away
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !$rose(out_valid))
        else $error("input not stalled or result too early after accept");

    // A zero gcd, which comes only from two zero operands, has x = 1 and y = 0
    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gcd_value == '0) |-> (coef_x == WIDTH'(1)) && (coef_y == '0))
        else $error("zero gcd with wrong coefficients");

    // A non-negative coefficient is its own inverse
    a_inv_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !coef_x[WIDTH-1] |-> inverse_value == coef_x[WIDTH-2:0])
        else $error("inverse differs from non-negative coefficient");

endmodule

bind extended_gcd_mod_inverse egcd_checker #(.WIDTH(WIDTH)) u_egcd_checker (.*);
